/* rtl/core/gaps_pkg.sv */
// shared types and constants for the grid path search block
`timescale 1ns / 1ps
package gaps_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 6;
  localparam int MOVE_MAX = 1023;
  localparam int STEP_COST = 10;
  localparam int PATH_DEPTH = 1024;
  localparam int PATH_AW = 10;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [1:0] DIR_UP = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;
  localparam logic [1:0] DIR_LEFT = 2'd3;

  localparam logic [1:0] FLAG_OPEN = 2'b01;
  localparam logic [1:0] FLAG_CLOSED = 2'b10;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] pos_x;
    logic [4:0] pos_y;
    logic [4:0] target_x;
    logic [4:0] target_y;
    logic       cell_blocked;
    logic       cell_occupied;
    logic [9:0] step_index;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [9:0] move_count;
    logic [4:0] step_x;
    logic [4:0] step_y;
    logic       step_is_target;
    logic       step_valid;
  } rsp_t;

endpackage

/* rtl/core/gaps_cmp.sv */
// open-set candidate compare: least f, then least h, then earliest stamp
`timescale 1ns / 1ps
module gaps_cmp #(
  parameter int FW = 17,
  parameter int HW = 11,
  parameter int SW = 11
) (
  input  logic          best_v,
  input  logic [FW-1:0] best_f,
  input  logic [HW-1:0] best_h,
  input  logic [SW-1:0] best_st,
  input  logic [FW-1:0] cand_f,
  input  logic [HW-1:0] cand_h,
  input  logic [SW-1:0] cand_st,
  output logic          take
);
  always_comb begin
    take = !best_v || (cand_f < best_f) ||
           ((cand_f == best_f) && ((cand_h < best_h) ||
           ((cand_h == best_h) && (cand_st < best_st))));
  end
endmodule

/* rtl/core/grid_astar_path_search.sv */
// 4-connected grid path search: cell map, search sequencer and path store
// load, unused code and out-of-path reads register the response at accept; a path read goes via S_RDOUT
// a search first clears the open/closed flags, then per expansion runs
//   an open-set scan over all cells, a pick and a block check, then an address and an
//   evaluation step per neighbor, then walks a found path back twice, to count and to store it
// one item at a time: the scan through the node memory sets the search time
// sync reset clears control; a clearing pass then zeroes the cell map and the flags
`timescale 1ns / 1ps
module grid_astar_path_search #(
  parameter int MAX_DIM = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  gaps_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output gaps_pkg::rsp_t                    rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gaps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gaps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gaps_pkg::*;

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int XW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = $clog2(CELLS);
  localparam int NW = $clog2(CELLS + 1);
  localparam int HW = $clog2(20 * MAX_DIM);
  localparam int GW = $clog2(10 * CELLS);
  localparam int FW = GW + 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_INIT, S_START, S_SCAN, S_PICK, S_BLK, S_NADR, S_NEV,
    S_CNT, S_CNT2, S_WR, S_WR2, S_RDOUT
  } state_t;

  state_t state;

  logic [5:0] grid_width, grid_height;
  logic [DW-1:0] eff_w, eff_h;
  logic res_found;
  logic [9:0] res_count;
  logic [NW-1:0] clr_cnt;

  // memories
  logic [1:0]    cell_map [CELLS];
  logic [1:0]    flags    [CELLS];
  logic [GW-1:0] g_cost   [CELLS];
  logic [HW-1:0] h_cost   [CELLS];
  logic [1:0]    parent   [CELLS];
  logic [NW-1:0] stamp    [CELLS];
  logic [2*XW-1:0] path_store [PATH_DEPTH];

  logic cm_we, fl_we, nd_we, st_we, pa_we;
  logic [CW-1:0] cm_wa, fl_wa, nd_wa, cm_ra, fl_ra, nd_ra, par_ra;
  logic [1:0] cm_wd, fl_wd, par_wd;
  logic [GW-1:0] g_wd;
  logic [HW-1:0] h_wd;
  logic [NW-1:0] st_wd;
  logic [PATH_AW-1:0] pa_wa, pa_ra;
  logic [2*XW-1:0] pa_wd;
  logic [1:0] cm_q, fl_q, par_q;
  logic [GW-1:0] g_q;
  logic [HW-1:0] h_q;
  logic [NW-1:0] st_q;
  logic [2*XW-1:0] pa_q;

  // search context
  logic [XW-1:0] sx, sy, tx, ty;
  logic [CW-1:0] s_idx, t_idx;
  logic [NW-1:0] next_stamp;
  logic [NW-1:0] scan_cnt;
  logic [XW-1:0] scan_x, scan_y, p_x, p_y;
  logic [CW-1:0] p_idx;
  logic p_v;
  logic best_v;
  logic [FW-1:0] best_f;
  logic [GW-1:0] best_g;
  logic [HW-1:0] best_h;
  logic [NW-1:0] best_st;
  logic [XW-1:0] best_x, best_y;
  logic [CW-1:0] best_idx;
  logic [1:0] dir;
  logic [XW-1:0] n_x, n_y;
  logic [CW-1:0] n_idx;
  logic [XW-1:0] c_x, c_y;
  logic [CW-1:0] c_idx;
  logic [NW-1:0] n_moves, k_cnt;
  logic [9:0] rd_si;

  logic take;
  logic [FW-1:0] cand_f;
  logic nb_ok;
  logic [XW-1:0] nb_x, nb_y;
  logic [CW-1:0] nb_idx;
  logic [GW-1:0] mc;
  logic nb_upd;
  logic [XW-1:0] st_x, st_y;
  logic accept;
  logic [9:0] sat_moves;

  function automatic logic [CW-1:0] cell_of(input logic [XW-1:0] x, input logic [XW-1:0] y);
    return CW'(32'(y) * MAX_DIM + 32'(x));
  endfunction

  function automatic logic [HW-1:0] dist10(input logic [XW-1:0] x, input logic [XW-1:0] y,
                                           input logic [XW-1:0] ax_t,
                                           input logic [XW-1:0] ay_t);
    logic [XW-1:0] ax, ay;
    logic [XW:0] sum;
    ax = (x > ax_t) ? x - ax_t : ax_t - x;
    ay = (y > ay_t) ? y - ay_t : ay_t - y;
    sum = {1'b0, ax} + {1'b0, ay};
    return HW'(32'(sum) * STEP_COST);
  endfunction

  assign eff_w = (32'(grid_width) > MAX_DIM) ? DW'(MAX_DIM) : DW'(grid_width);
  assign eff_h = (32'(grid_height) > MAX_DIM) ? DW'(MAX_DIM) : DW'(grid_height);
  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign cfg_ready = 1'b1;
  assign accept = req_valid && req_ready;
  assign cand_f = FW'(g_q) + FW'(h_q);
  assign mc = best_g + GW'(STEP_COST);
  assign nb_upd = (cm_q == 2'b00) && !fl_q[1] && (!fl_q[0] || (mc < g_q));
  assign sat_moves = (32'(n_moves) > MOVE_MAX) ? 10'(MOVE_MAX) : 10'(n_moves);
  assign st_x = XW'(req.pos_x);
  assign st_y = XW'(req.pos_y);

  gaps_cmp #(.FW(FW), .HW(HW), .SW(NW)) u_cmp (
    .best_v (best_v),
    .best_f (best_f),
    .best_h (best_h),
    .best_st(best_st),
    .cand_f (cand_f),
    .cand_h (h_q),
    .cand_st(st_q),
    .take   (take)
  );

  // neighbor of the expanded cell in the current direction
  always_comb begin
    nb_x = best_x;
    nb_y = best_y;
    nb_ok = 1'b0;
    unique case (dir)
      DIR_UP: begin
        nb_y = best_y + XW'(1);
        nb_ok = (32'(best_y) + 1) < 32'(eff_h);
      end
      DIR_RIGHT: begin
        nb_x = best_x + XW'(1);
        nb_ok = (32'(best_x) + 1) < 32'(eff_w);
      end
      DIR_DOWN: begin
        nb_y = best_y - XW'(1);
        nb_ok = best_y != '0;
      end
      default: begin
        nb_x = best_x - XW'(1);
        nb_ok = best_x != '0;
      end
    endcase
    nb_idx = cell_of(nb_x, nb_y);
  end

  // memory port control
  always_comb begin
    cm_we = 1'b0; cm_wa = '0; cm_wd = '0; cm_ra = best_idx;
    fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = scan_cnt[CW-1:0];
    nd_we = 1'b0; nd_wa = n_idx; g_wd = '0; h_wd = '0; par_wd = dir;
    st_we = 1'b0; st_wd = next_stamp; nd_ra = scan_cnt[CW-1:0];
    par_ra = c_idx;
    pa_we = 1'b0; pa_wa = PATH_AW'(k_cnt - NW'(1)); pa_wd = {c_y, c_x};
    pa_ra = req.step_index;
    unique case (state)
      S_CLR: begin
        cm_we = 1'b1; cm_wa = clr_cnt[CW-1:0];
        fl_we = 1'b1; fl_wa = clr_cnt[CW-1:0];
      end
      S_IDLE: begin
        if (accept && req.req_type == REQ_LOAD && 32'(req.pos_x) < MAX_DIM &&
            32'(req.pos_y) < MAX_DIM) begin
          cm_we = 1'b1;
          cm_wa = cell_of(st_x, st_y);
          cm_wd = {req.cell_occupied, req.cell_blocked};
        end
      end
      S_INIT: begin
        fl_we = 1'b1; fl_wa = clr_cnt[CW-1:0];
      end
      S_START: begin
        fl_we = 1'b1; fl_wa = s_idx; fl_wd = FLAG_OPEN;
        nd_we = 1'b1; nd_wa = s_idx; h_wd = dist10(sx, sy, tx, ty);
        st_we = 1'b1; st_wd = '0;
      end
      S_PICK: begin
        if (best_v) begin
          fl_we = 1'b1; fl_wa = best_idx; fl_wd = FLAG_CLOSED;
        end
      end
      S_NADR: begin
        cm_ra = nb_idx; fl_ra = nb_idx; nd_ra = nb_idx;
      end
      S_NEV: begin
        if (nb_upd) begin
          nd_we = 1'b1; g_wd = mc; h_wd = dist10(n_x, n_y, tx, ty);
          if (!fl_q[0]) begin
            fl_we = 1'b1; fl_wa = n_idx; fl_wd = FLAG_OPEN;
            st_we = 1'b1;
          end
        end
      end
      S_WR: begin
        pa_we = (k_cnt != '0) && (32'(k_cnt) <= MOVE_MAX);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cm_we) cell_map[cm_wa] <= cm_wd;
    if (fl_we) flags[fl_wa] <= fl_wd;
    if (nd_we) begin
      g_cost[nd_wa] <= g_wd;
      h_cost[nd_wa] <= h_wd;
      parent[nd_wa] <= par_wd;
    end
    if (st_we) stamp[nd_wa] <= st_wd;
    if (pa_we) path_store[pa_wa] <= pa_wd;
    cm_q <= cell_map[cm_ra];
    fl_q <= flags[fl_ra];
    g_q <= g_cost[nd_ra];
    h_q <= h_cost[nd_ra];
    st_q <= stamp[nd_ra];
    par_q <= parent[par_ra];
    pa_q <= path_store[pa_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      grid_width <= 6'd32;
      grid_height <= 6'd32;
      res_found <= 1'b0;
      res_count <= '0;
      rsp_valid <= 1'b0;
      p_v <= 1'b0;
      best_v <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_WIDTH) grid_width <= cfg_data;
        else if (cfg_index == REG_GRID_HEIGHT) grid_height <= cfg_data;
      end
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      p_v <= (state == S_SCAN) && (32'(scan_cnt) < CELLS);

      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + NW'(1);
          if (32'(clr_cnt) == CELLS - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            rsp.found <= res_found;
            rsp.move_count <= res_count;
            rsp.step_x <= '0;
            rsp.step_y <= '0;
            rsp.step_is_target <= 1'b0;
            rsp.step_valid <= 1'b0;
            priority if (req.req_type == REQ_SEARCH) begin
              sx <= st_x; sy <= st_y;
              tx <= XW'(req.target_x); ty <= XW'(req.target_y);
              s_idx <= cell_of(st_x, st_y);
              t_idx <= cell_of(XW'(req.target_x), XW'(req.target_y));
              res_found <= 1'b0;
              res_count <= '0;
              clr_cnt <= '0;
              if (32'(req.pos_x) >= 32'(eff_w) || 32'(req.pos_y) >= 32'(eff_h) ||
                  32'(req.target_x) >= 32'(eff_w) || 32'(req.target_y) >= 32'(eff_h)) begin
                rsp.found <= 1'b0;
                rsp.move_count <= '0;
                rsp_valid <= 1'b1;
              end else begin
                state <= S_INIT;
              end
            end else if (req.req_type == REQ_READ && req.step_index < res_count) begin
              rd_si <= req.step_index;
              state <= S_RDOUT;
            end else begin
              rsp_valid <= 1'b1;
            end
          end
        end
        S_INIT: begin
          clr_cnt <= clr_cnt + NW'(1);
          if (32'(clr_cnt) == CELLS - 1) state <= S_START;
        end
        S_START: begin
          next_stamp <= NW'(1);
          scan_cnt <= '0; scan_x <= '0; scan_y <= '0;
          best_v <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (p_v && fl_q[0] && take) begin
            best_v <= 1'b1;
            best_f <= cand_f;
            best_g <= g_q;
            best_h <= h_q;
            best_st <= st_q;
            best_x <= p_x;
            best_y <= p_y;
            best_idx <= p_idx;
          end
          if (32'(scan_cnt) < CELLS) begin
            p_x <= scan_x; p_y <= scan_y; p_idx <= scan_cnt[CW-1:0];
            scan_cnt <= scan_cnt + NW'(1);
            if (32'(scan_x) == MAX_DIM - 1) begin
              scan_x <= '0;
              scan_y <= scan_y + XW'(1);
            end else begin
              scan_x <= scan_x + XW'(1);
            end
          end else begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          priority if (!best_v) begin
            rsp.found <= 1'b0;
            rsp.move_count <= '0;
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end else if (best_idx == t_idx) begin
            c_x <= best_x; c_y <= best_y; c_idx <= best_idx;
            n_moves <= '0;
            state <= S_CNT;
          end else begin
            state <= S_BLK;
          end
        end
        S_BLK: begin
          dir <= DIR_UP;
          scan_cnt <= '0; scan_x <= '0; scan_y <= '0;
          best_v <= 1'b0;
          // a blocked cell gives no moves
          if (cm_q[0]) state <= S_SCAN;
          else state <= S_NADR;
        end
        S_NADR: begin
          n_x <= nb_x; n_y <= nb_y; n_idx <= nb_idx;
          if (nb_ok) begin
            state <= S_NEV;
          end else if (dir == DIR_LEFT) begin
            best_v <= 1'b0;
            state <= S_SCAN;
          end else begin
            dir <= dir + 2'd1;
          end
        end
        S_NEV: begin
          if (nb_upd && !fl_q[0]) next_stamp <= next_stamp + NW'(1);
          if (dir == DIR_LEFT) begin
            best_v <= 1'b0;
            state <= S_SCAN;
          end else begin
            dir <= dir + 2'd1;
            state <= S_NADR;
          end
        end
        S_CNT: begin
          if (c_idx == s_idx || 32'(n_moves) >= CELLS) begin
            c_x <= tx; c_y <= ty; c_idx <= t_idx;
            k_cnt <= n_moves;
            state <= S_WR;
          end else begin
            state <= S_CNT2;
          end
        end
        S_CNT2: begin
          n_moves <= n_moves + NW'(1);
          state <= S_CNT;
          unique case (par_q)
            DIR_UP: begin c_y <= c_y - XW'(1); c_idx <= cell_of(c_x, c_y - XW'(1)); end
            DIR_RIGHT: begin c_x <= c_x - XW'(1); c_idx <= cell_of(c_x - XW'(1), c_y); end
            DIR_DOWN: begin c_y <= c_y + XW'(1); c_idx <= cell_of(c_x, c_y + XW'(1)); end
            default: begin c_x <= c_x + XW'(1); c_idx <= cell_of(c_x + XW'(1), c_y); end
          endcase
        end
        S_WR: begin
          if (k_cnt == '0) begin
            res_found <= 1'b1;
            res_count <= sat_moves;
            rsp.found <= 1'b1;
            rsp.move_count <= sat_moves;
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_WR2;
          end
        end
        S_WR2: begin
          k_cnt <= k_cnt - NW'(1);
          state <= S_WR;
          unique case (par_q)
            DIR_UP: begin c_y <= c_y - XW'(1); c_idx <= cell_of(c_x, c_y - XW'(1)); end
            DIR_RIGHT: begin c_x <= c_x - XW'(1); c_idx <= cell_of(c_x - XW'(1), c_y); end
            DIR_DOWN: begin c_y <= c_y + XW'(1); c_idx <= cell_of(c_x, c_y + XW'(1)); end
            default: begin c_x <= c_x + XW'(1); c_idx <= cell_of(c_x + XW'(1), c_y); end
          endcase
        end
        S_RDOUT: begin
          rsp.step_x <= 5'(pa_q[XW-1:0]);
          rsp.step_y <= 5'(pa_q[2*XW-1:XW]);
          rsp.step_valid <= 1'b1;
          rsp.step_is_target <= (rd_si + 10'd1) == res_count;
          rsp_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/gaps_chk.sv */
// port checks for the grid path search block, bound to the top level
`timescale 1ns / 1ps
module gaps_chk (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input gaps_pkg::rsp_t rsp
);
  import gaps_pkg::*;

  // a path step exists only on a found path
  a_step_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.step_valid |-> rsp.found && rsp.move_count != 10'd0)
    else $error("step item without a found path");

  a_target_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.step_is_target |-> rsp.step_valid)
    else $error("target mark on an invalid step");

  a_step_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.step_valid |-> rsp.step_x == 5'd0 && rsp.step_y == 5'd0)
    else $error("step fields not zero on an invalid step");

  a_count_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.move_count == 10'd0)
    else $error("move count without found");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("item dropped or changed while stalled");
endmodule

bind grid_astar_path_search gaps_chk u_gaps_chk (
  .clk(clk), .rst(rst), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);

/* dv/tb.sv */
// testbench for the grid path search block: directed and random load, search and path read items
`timescale 1ns / 1ps
module tb;
  import gaps_pkg::*;

  localparam int DIM = 32;
  localparam int NCELL = DIM * DIM;
  localparam int WATCHDOG_LIMIT = 6000000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // reference behavior of the block plus the queue of expected responses
  class path_scoreboard;
    bit [1:0] cell_flags[NCELL];
    int unsigned g_val[NCELL];
    int unsigned h_val[NCELL];
    int unsigned stamp[NCELL];
    bit [1:0] from_dir[NCELL];
    bit [1:0] state_flags[NCELL];
    bit [9:0] path_cells[1024];
    bit found;
    bit [9:0] moves;
    int unsigned cols = 32;
    int unsigned rows = 32;
    rsp_t expected_rsp[$];
    int errors = 0;

    function int unsigned clip(int unsigned v);
      return (v > DIM) ? DIM : v;
    endfunction

    function int unsigned manhattan10(int x, int y, int tx, int ty);
      return ((x > tx ? x - tx : tx - x) + (y > ty ? y - ty : ty - y)) * STEP_COST;
    endfunction

    function int step_back(int c, bit [1:0] d);
      int x;
      int y;
      x = c % DIM;
      y = c / DIM;
      case (d)
        DIR_UP: y = y - 1;
        DIR_RIGHT: x = x - 1;
        DIR_DOWN: y = y + 1;
        default: x = x + 1;
      endcase
      return y * DIM + x;
    endfunction

    function void search_path(int sx, int sy, int tx, int ty);
      int w;
      int h;
      int s;
      int t;
      int best;
      int nx;
      int ny;
      int nb;
      int c;
      int n;
      int unsigned next_stamp;
      int unsigned f;
      int unsigned bf;
      int unsigned mc;
      w = clip(cols);
      h = clip(rows);
      found = 0;
      moves = 0;
      if (sx >= w || sy >= h || tx >= w || ty >= h) return;
      foreach (state_flags[i]) state_flags[i] = 0;
      s = sy * DIM + sx;
      t = ty * DIM + tx;
      g_val[s] = 0;
      h_val[s] = manhattan10(sx, sy, tx, ty);
      stamp[s] = 0;
      state_flags[s] = FLAG_OPEN;
      next_stamp = 1;
      forever begin
        best = -1;
        for (int i = 0; i < NCELL; i++) begin
          if (!(state_flags[i] & FLAG_OPEN)) continue;
          if (best < 0) begin
            best = i;
            continue;
          end
          f = g_val[i] + h_val[i];
          bf = g_val[best] + h_val[best];
          if (f < bf || (f == bf && (h_val[i] < h_val[best] ||
              (h_val[i] == h_val[best] && stamp[i] < stamp[best]))))
            best = i;
        end
        if (best < 0) return;
        state_flags[best] = FLAG_CLOSED;
        if (best == t) begin
          n = 0;
          c = t;
          while (c != s && n < NCELL) begin
            c = step_back(c, from_dir[c]);
            n++;
          end
          c = t;
          for (int k = n; k > 0; k--) begin
            if (k - 1 < MOVE_MAX) path_cells[k-1] = c[9:0];
            c = step_back(c, from_dir[c]);
          end
          found = 1;
          moves = 10'((n > MOVE_MAX) ? MOVE_MAX : n);
          return;
        end
        if (cell_flags[best][0]) continue;
        for (int d = 0; d < 4; d++) begin
          nx = best % DIM + ((d == 1) ? 1 : (d == 3) ? -1 : 0);
          ny = best / DIM + ((d == 0) ? 1 : (d == 2) ? -1 : 0);
          if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
          nb = ny * DIM + nx;
          if (cell_flags[nb] != 0 || (state_flags[nb] & FLAG_CLOSED)) continue;
          mc = g_val[best] + STEP_COST;
          if (!(state_flags[nb] & FLAG_OPEN) || mc < g_val[nb]) begin
            g_val[nb] = mc;
            h_val[nb] = manhattan10(nx, ny, tx, ty);
            from_dir[nb] = d[1:0];
            if (!(state_flags[nb] & FLAG_OPEN)) begin
              state_flags[nb] = FLAG_OPEN;
              stamp[nb] = next_stamp++;
            end
          end
        end
      end
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      bit [9:0] p;
      if (r.req_type == REQ_LOAD)
        cell_flags[r.pos_y * DIM + r.pos_x] = {r.cell_occupied, r.cell_blocked};
      else if (r.req_type == REQ_SEARCH)
        search_path(r.pos_x, r.pos_y, r.target_x, r.target_y);
      e = '0;
      e.found = found;
      e.move_count = moves;
      if (r.req_type == REQ_READ && r.step_index < moves) begin
        p = path_cells[r.step_index];
        e.step_valid = 1;
        e.step_x = 5'(p % DIM);
        e.step_y = 5'(p / DIM);
        e.step_is_target = (r.step_index + 1 == moves);
      end
      expected_rsp.push_back(e);
    endfunction

    function void check_response(rsp_t a);
      rsp_t e;
      if (expected_rsp.size() == 0) begin
        $error("response with no request pending: %h", a);
        errors++;
        return;
      end
      e = expected_rsp.pop_front();
      if (a.found !== e.found) begin
        $error("found: expected %0d actual %0d", e.found, a.found);
        errors++;
      end
      if (a.move_count !== e.move_count) begin
        $error("move_count: expected %0d actual %0d", e.move_count, a.move_count);
        errors++;
      end
      if (a.step_x !== e.step_x) begin
        $error("step_x: expected %0d actual %0d", e.step_x, a.step_x);
        errors++;
      end
      if (a.step_y !== e.step_y) begin
        $error("step_y: expected %0d actual %0d", e.step_y, a.step_y);
        errors++;
      end
      if (a.step_is_target !== e.step_is_target) begin
        $error("step_is_target: expected %0d actual %0d", e.step_is_target, a.step_is_target);
        errors++;
      end
      if (a.step_valid !== e.step_valid) begin
        $error("step_valid: expected %0d actual %0d", e.step_valid, a.step_valid);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  rsp_t rsp;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  path_scoreboard sb = new();
  bit no_gaps = 0;
  int rsp_seen = 0;
  int sent = 0;

  grid_astar_path_search dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // stall counter: any accepted item or register write resets it
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // response side: random stalls, one long hold-off so the block backs up
  initial begin
    int hold;
    bit held_once;
    hold = 0;
    held_once = 0;
    forever begin
      @(posedge clk);
      if (rst) continue;
      if (rsp_valid && rsp_ready) begin
        sb.check_response(rsp);
        rsp_seen++;
      end
      if (!held_once && rsp_seen == 300) begin
        held_once = 1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        rsp_ready <= 0;
      end else begin
        rsp_ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 34);
      end
    end
  end

  task automatic send_item(req_t r);
    if (!no_gaps && $urandom_range(99) < 34) begin
      req_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
    sent++;
    no_gaps = (sent >= 400 && sent < 520);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    req_valid <= 0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == REG_GRID_WIDTH) sb.cols = val;
    else if (idx == REG_GRID_HEIGHT) sb.rows = val;
  endtask

  function automatic req_t make_req(logic [1:0] kind, int px, int py, int tx, int ty,
                                    bit blk, bit occ, int idx);
    req_t r;
    r = '0;
    r.req_type = kind;
    r.pos_x = 5'(px);
    r.pos_y = 5'(py);
    r.target_x = 5'(tx);
    r.target_y = 5'(ty);
    r.cell_blocked = blk;
    r.cell_occupied = occ;
    r.step_index = 10'(idx);
    return r;
  endfunction

  function automatic int pick_coord(int unsigned lim);
    int unsigned m;
    m = (lim > DIM) ? DIM : lim;
    return (m == 0) ? $urandom_range(31) : $urandom_range(m - 1);
  endfunction

  // well-formed load/search/read sequences, with a share of raw noise items
  task automatic random_phase(int count, bit wide_grid);
    int start;
    int sx;
    int sy;
    int tx;
    int ty;
    req_t r;
    start = sent;
    while (sent - start < count) begin
      if ($urandom_range(99) < 75) begin
        repeat ($urandom_range(0, 4)) begin
          r = make_req(REQ_LOAD, pick_coord(sb.cols), pick_coord(sb.rows), $urandom_range(31),
                       $urandom_range(31), $urandom_range(99) < 20, $urandom_range(99) < 8,
                       $urandom_range(1023));
          send_item(r);
        end
        sx = pick_coord(sb.cols);
        sy = pick_coord(sb.rows);
        if (wide_grid) begin
          tx = (sx + $urandom_range(3)) % DIM;
          ty = sy;
        end else begin
          tx = pick_coord(sb.cols);
          ty = pick_coord(sb.rows);
        end
        if (!wide_grid && $urandom_range(99) < 8) tx = $urandom_range(31);
        send_item(make_req(REQ_SEARCH, sx, sy, tx, ty, $urandom_range(1), $urandom_range(1),
                           $urandom_range(1023)));
        for (int i = 0; i <= sb.moves && i < 12; i++)
          send_item(make_req(REQ_READ, $urandom_range(31), $urandom_range(31),
                             $urandom_range(31), $urandom_range(31), $urandom_range(1),
                             $urandom_range(1), i));
      end else begin
        r = 34'({$urandom(), $urandom()});
        if (r.req_type == REQ_SEARCH && wide_grid) r.req_type = REQ_READ;
        send_item(r);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: extremes, unused code, trivial and short searches, reads past the path
    send_item(make_req(REQ_LOAD, 0, 0, 0, 0, 1, 0, 0));
    send_item(make_req(REQ_LOAD, 31, 31, 31, 31, 1, 1, 1023));
    send_item(make_req(REQ_UNUSED, 5, 5, 7, 7, 1, 1, 5));
    send_item(make_req(REQ_SEARCH, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_req(REQ_SEARCH, 1, 0, 3, 0, 0, 0, 0));
    send_item(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 1));
    send_item(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 2));
    send_item(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 1023));
    send_item(make_req(REQ_LOAD, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_req(REQ_LOAD, 31, 31, 0, 0, 0, 0, 0));

    write_reg(REG_GRID_WIDTH, 6'd4);
    write_reg(REG_GRID_HEIGHT, 6'd4);
    // occupied target, blocked start, target outside the grid, blocked start on target
    send_item(make_req(REQ_LOAD, 3, 3, 0, 0, 0, 1, 0));
    send_item(make_req(REQ_SEARCH, 0, 1, 3, 3, 0, 0, 0));
    send_item(make_req(REQ_LOAD, 0, 0, 0, 0, 1, 0, 0));
    send_item(make_req(REQ_SEARCH, 0, 0, 2, 2, 0, 0, 0));
    send_item(make_req(REQ_SEARCH, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_req(REQ_SEARCH, 1, 1, 5, 1, 0, 0, 0));
    send_item(make_req(REQ_LOAD, 3, 3, 0, 0, 0, 0, 0));
    send_item(make_req(REQ_LOAD, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_req(REQ_SEARCH, 0, 0, 3, 3, 0, 0, 0));
    send_item(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 5));

    random_phase(200, 0);
    write_reg(REG_GRID_WIDTH, 6'd1);
    write_reg(REG_GRID_HEIGHT, 6'd1);
    random_phase(60, 0);
    write_reg(REG_GRID_WIDTH, 6'd0);
    write_reg(REG_GRID_HEIGHT, 6'd5);
    random_phase(40, 0);
    write_reg(REG_GRID_WIDTH, 6'd63);
    write_reg(REG_GRID_HEIGHT, 6'd3);
    random_phase(120, 0);
    write_reg(2'd2, 6'h2a);
    write_reg(2'd3, 6'h15);
    write_reg(REG_GRID_WIDTH, 6'd6);
    write_reg(REG_GRID_HEIGHT, 6'd6);
    random_phase(200, 0);
    write_reg(REG_GRID_WIDTH, 6'd5);
    write_reg(REG_GRID_HEIGHT, 6'd1);
    random_phase(80, 0);
    write_reg(REG_GRID_WIDTH, 6'd3);
    write_reg(REG_GRID_HEIGHT, 6'd8);
    random_phase(150, 0);
    write_reg(REG_GRID_WIDTH, 6'd32);
    write_reg(REG_GRID_HEIGHT, 6'd32);
    random_phase(40, 1);

    req_valid <= 0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_rsp.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/gaps_pkg.sv
rtl/core/gaps_cmp.sv
rtl/core/grid_astar_path_search.sv
rtl/core/gaps_chk.sv
dv/tb.sv
